### src/lbd_pkg.sv
// ----------------------------------------------------------------------------
// lbd_pkg: shared types and constants for the letterbox bar detector
// Pixel and crop payload types, register map, reset values and the control
// group passed from the box tracker to the result stage.
// ----------------------------------------------------------------------------
package lbd_pkg;

	localparam int CFG_W   = 14;	// widest config register
	localparam int CHAN_W  = 8;
	localparam int POS_W   = 13;
	localparam int SIZE_W  = 14;
	localparam int CFG_IDX_W = 2;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT,
		REG_DARK_THRESHOLD,
		REG_MIN_CONTENT_SIZE
	} cfg_reg_t;

	// reset values
	localparam logic [CFG_W-1:0]  RST_FRAME_WIDTH  = 14'd1920;
	localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT = 14'd1080;
	localparam logic [CHAN_W-1:0] RST_DARK_THRESHOLD = 8'd5;
	localparam logic [CFG_W-1:0]  RST_MIN_CONTENT  = 14'd64;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [POS_W-1:0]  crop_left;
		logic [POS_W-1:0]  crop_top;
		logic [SIZE_W-1:0] crop_width;
		logic [SIZE_W-1:0] crop_height;
		logic              cropped;
	} crop_t;

	// tracker -> result stage
	typedef struct packed {
		logic frame_end;	// last pixel of the frame retires this cycle
		logic any_bright;	// the tracker's box outputs hold a valid box
	} box_ctl_t;

endpackage

### src/lbd_ifs.sv
// ----------------------------------------------------------------------------
// lbd_ifs: valid/ready stream interfaces
// Pixel input stream and crop result stream.
// ----------------------------------------------------------------------------
interface lbd_pix_if;
	import lbd_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lbd_crop_if;
	import lbd_pkg::*;

	logic  valid;
	logic  ready;
	crop_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### src/lbd_box_track.sv
// ----------------------------------------------------------------------------
// lbd_box_track: input register, raster counters and bright-pixel box
// Registers one pixel beat, classifies it, advances the column/row counters
// and keeps the bounding box of bright pixels for the current frame.
// ----------------------------------------------------------------------------
module lbd_box_track #(
	parameter int MAX_WIDTH  = 8192,
	parameter int MAX_HEIGHT = 8192
) (
	input  logic                               clk,
	input  logic                               arst_n,
	lbd_pix_if.sink                            pix,
	input  logic [$clog2(MAX_WIDTH):0]         w_eff,
	input  logic [$clog2(MAX_HEIGHT):0]        h_eff,
	input  logic [lbd_pkg::CHAN_W-1:0]         thr,
	input  logic                               out_free,
	output lbd_pkg::box_ctl_t                  ctl,
	output logic [$clog2(MAX_WIDTH)-1:0]       box_first_col,
	output logic [$clog2(MAX_WIDTH)-1:0]       box_last_col,
	output logic [$clog2(MAX_HEIGHT)-1:0]      box_first_row,
	output logic [$clog2(MAX_HEIGHT)-1:0]      box_last_row
);
	import lbd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic          vld_s1;
	pixel_t        pix_s1;
	logic [CW-1:0] col_q, first_col_q, last_col_q;
	logic [RW-1:0] row_q, first_row_q, last_row_q;
	logic          any_q;

	logic          bright, row_end, frame_end, adv;
	logic [CW:0]   col_inc;
	logic [RW:0]   row_inc;
	logic          nb_any;
	logic [CW-1:0] nb_first_col, nb_last_col;
	logic [RW-1:0] nb_first_row, nb_last_row;

	// position and stall decision
	assign col_inc   = {1'b0, col_q} + 1'b1;
	assign row_inc   = {1'b0, row_q} + 1'b1;
	assign row_end   = !(col_inc < w_eff);
	assign frame_end = row_end && !(row_inc < h_eff);
	assign adv       = vld_s1 && (!frame_end || out_free);
	assign pix.ready = !vld_s1 || adv;

	// any channel above threshold
	assign bright = (pix_s1.red > thr) || (pix_s1.green > thr) || (pix_s1.blue > thr);

	// box including the current pixel
	always_comb begin
		nb_any       = any_q;
		nb_first_col = first_col_q;
		nb_last_col  = last_col_q;
		nb_first_row = first_row_q;
		nb_last_row  = last_row_q;
		if (bright) begin
			nb_any = 1'b1;
			if (!any_q) begin
				nb_first_col = col_q;
				nb_last_col  = col_q;
				nb_first_row = row_q;
				nb_last_row  = row_q;
			end else begin
				if (col_q < first_col_q) nb_first_col = col_q;
				if (col_q > last_col_q)  nb_last_col  = col_q;
				if (row_q < first_row_q) nb_first_row = row_q;
				if (row_q > last_row_q)  nb_last_row  = row_q;
			end
		end
	end

	assign ctl.frame_end = adv && frame_end;
	assign ctl.any_bright = nb_any;
	assign box_first_col = nb_first_col;
	assign box_last_col  = nb_last_col;
	assign box_first_row = nb_first_row;
	assign box_last_row  = nb_last_row;

	// input register, valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pix.ready) begin
			vld_s1 <= pix.valid;
		end
	end

	// input register, payload
	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			pix_s1 <= pix.data;
		end
	end

	// counters and box
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			any_q       <= 1'b0;
			first_col_q <= '0;
			last_col_q  <= '0;
			first_row_q <= '0;
			last_row_q  <= '0;
		end else if (adv) begin
			if (frame_end) begin
				col_q       <= '0;
				row_q       <= '0;
				any_q       <= 1'b0;
				first_col_q <= '0;
				last_col_q  <= '0;
				first_row_q <= '0;
				last_row_q  <= '0;
			end else begin
				col_q       <= row_end ? '0 : col_inc[CW-1:0];
				row_q       <= row_end ? row_inc[RW-1:0] : row_q;
				any_q       <= nb_any;
				first_col_q <= nb_first_col;
				last_col_q  <= nb_last_col;
				first_row_q <= nb_first_row;
				last_row_q  <= nb_last_row;
			end
		end
	end

	// a retired frame leaves a clean tracker
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.frame_end |=> (col_q == '0) && (row_q == '0) && !any_q)
		else $error("tracker not cleared after frame end");

	// a stalled pixel stays in the input register
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> (vld_s1 && $stable(pix_s1) && $stable(col_q)))
		else $error("stalled pixel lost");

	// box corners stay ordered while valid
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		any_q |-> (first_col_q <= last_col_q) && (first_row_q <= last_row_q))
		else $error("bounding box inverted");

	// a result is only raised when the output stage can take it
	a_end_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.frame_end |-> out_free)
		else $error("frame end while result stage busy");

endmodule

### src/lbd_crop_out.sv
// ----------------------------------------------------------------------------
// lbd_crop_out: crop decision and result register
// Turns the final box into a crop rectangle, falling back to the full frame
// when no box, the whole frame or a too small box was found.
// ----------------------------------------------------------------------------
module lbd_crop_out #(
	parameter int MAX_WIDTH  = 8192,
	parameter int MAX_HEIGHT = 8192
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lbd_pkg::box_ctl_t                  ctl,
	input  logic [$clog2(MAX_WIDTH)-1:0]       box_first_col,
	input  logic [$clog2(MAX_WIDTH)-1:0]       box_last_col,
	input  logic [$clog2(MAX_HEIGHT)-1:0]      box_first_row,
	input  logic [$clog2(MAX_HEIGHT)-1:0]      box_last_row,
	input  logic [$clog2(MAX_WIDTH):0]         w_eff,
	input  logic [$clog2(MAX_HEIGHT):0]        h_eff,
	input  logic [lbd_pkg::CFG_W-1:0]          min_size,
	output logic                               out_free,
	lbd_crop_if.source                         crop
);
	import lbd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [CW:0]      bw;
	logic [RW:0]      bh;
	logic [CFG_W-1:0] min_eff;
	logic             whole, too_small;
	crop_t            res;
	logic             out_vld_q;
	crop_t            out_data_q;

	// box size and acceptance
	assign bw        = {1'b0, box_last_col} - {1'b0, box_first_col} + 1'b1;
	assign bh        = {1'b0, box_last_row} - {1'b0, box_first_row} + 1'b1;
	assign min_eff   = (min_size == '0) ? CFG_W'(1) : min_size;
	assign whole     = (bw == w_eff) && (bh == h_eff);
	assign too_small = (32'(bw) < 32'(min_eff)) || (32'(bh) < 32'(min_eff));

	// result select
	always_comb begin
		res.crop_left   = '0;
		res.crop_top    = '0;
		res.crop_width  = SIZE_W'(w_eff);
		res.crop_height = SIZE_W'(h_eff);
		res.cropped     = 1'b0;
		if (ctl.any_bright && !whole && !too_small) begin
			res.crop_left   = POS_W'(box_first_col);
			res.crop_top    = POS_W'(box_first_row);
			res.crop_width  = SIZE_W'(bw);
			res.crop_height = SIZE_W'(bh);
			res.cropped     = 1'b1;
		end
	end

	assign out_free   = !out_vld_q || crop.ready;
	assign crop.valid = out_vld_q;
	assign crop.data  = out_data_q;

	// result register, valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= ctl.frame_end;
		end
	end

	// result register, payload
	always_ff @(posedge clk) begin
		if (ctl.frame_end) begin
			out_data_q <= res;
		end
	end

endmodule

### src/letterbox_bar_detect.sv
// ----------------------------------------------------------------------------
// letterbox_bar_detect: letterbox / pillarbox bar detector
// Finds the bounding box of bright pixels per frame and reports a crop
// rectangle on each frame's last pixel.
// ----------------------------------------------------------------------------
// The block takes one RGB pixel per clock in raster order and keeps up with
// a continuous stream: a pixel passes an input register, then the counter and
// box update logic; each frame's last beat loads the result register behind
// the crop output. Input ready drops only while a frame's last pixel waits
// for the result register, i.e. when the previous crop result is still unread;
// otherwise throughput is one pixel per cycle. The user must write frame size
// and thresholds via the config port while the stream is idle (not enforced).
// ----------------------------------------------------------------------------
module letterbox_bar_detect #(
	parameter int MAX_WIDTH  = 8192,
	parameter int MAX_HEIGHT = 8192
) (
	input  logic                            clk,
	input  logic                            arst_n,
	lbd_pix_if.sink                         pix,
	lbd_crop_if.source                      crop,
	input  logic                            cfg_we,
	input  logic [lbd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lbd_pkg::CFG_W-1:0]       cfg_data
);
	import lbd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [CFG_W-1:0]  frame_width_q, frame_height_q, min_size_q;
	logic [CHAN_W-1:0] thr_q;
	logic [CW:0]       w_eff;
	logic [RW:0]       h_eff;
	logic              out_free;
	box_ctl_t          ctl;
	logic [CW-1:0]     box_first_col, box_last_col;
	logic [RW-1:0]     box_first_row, box_last_row;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			thr_q          <= RST_DARK_THRESHOLD;
			min_size_q     <= RST_MIN_CONTENT;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:      frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT:     frame_height_q <= cfg_data;
				REG_DARK_THRESHOLD:   thr_q          <= cfg_data[CHAN_W-1:0];
				REG_MIN_CONTENT_SIZE: min_size_q     <= cfg_data;
				default:              ;
			endcase
		end
	end

	// frame size saturated to 1..MAX
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = (CW+1)'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_eff = (CW+1)'(MAX_WIDTH);
		end else begin
			w_eff = (CW+1)'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = (RW+1)'(1);
		end else if (32'(frame_height_q) > MAX_HEIGHT) begin
			h_eff = (RW+1)'(MAX_HEIGHT);
		end else begin
			h_eff = (RW+1)'(frame_height_q);
		end
	end

	lbd_box_track #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix           (pix),
		.w_eff         (w_eff),
		.h_eff         (h_eff),
		.thr           (thr_q),
		.out_free      (out_free),
		.ctl           (ctl),
		.box_first_col (box_first_col),
		.box_last_col  (box_last_col),
		.box_first_row (box_first_row),
		.box_last_row  (box_last_row)
	);

	lbd_crop_out #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.box_first_col (box_first_col),
		.box_last_col  (box_last_col),
		.box_first_row (box_first_row),
		.box_last_row  (box_last_row),
		.w_eff         (w_eff),
		.h_eff         (h_eff),
		.min_size      (min_size_q),
		.out_free      (out_free),
		.crop          (crop)
	);

endmodule
